// File: hw/rtl/lpep_pkg.sv
// Shared types, codes and sizing constants for the log-pattern expression parser.
package lpep_pkg;

  localparam int unsigned MaxExprLen = 4096;
  localparam int unsigned PosW       = 13;
  localparam int unsigned StartW     = 12;
  localparam int unsigned LenW       = 13;

  // result queue sizing: one character yields at most three records
  localparam int unsigned MaxRecs    = 3;
  localparam int unsigned RecCntW    = 2;
  localparam int unsigned QueueDepth = 8;
  localparam int unsigned QueuePtrW  = 3;
  localparam int unsigned QueueCntW  = 4;

  typedef logic [7:0] char_t;

  localparam char_t ChNul = 8'h00;
  localparam char_t ChLt  = 8'h3C;
  localparam char_t ChGt  = 8'h3E;
  localparam char_t ChQm  = 8'h3F;
  localparam char_t ChBsl = 8'h5C;

  // parser phases
  localparam logic [3:0] PhTop       = 4'd0;
  localparam logic [3:0] PhLit       = 4'd1;
  localparam logic [3:0] PhOpen      = 4'd2;
  localparam logic [3:0] PhOpt       = 4'd3;
  localparam logic [3:0] PhName      = 4'd4;
  localparam logic [3:0] PhClosed    = 4'd5;
  localparam logic [3:0] PhAltQ      = 4'd6;
  localparam logic [3:0] PhAltOpen   = 4'd7;
  localparam logic [3:0] PhAltName   = 4'd8;
  localparam logic [3:0] PhAltClosed = 4'd9;

  typedef enum logic [2:0] {
    KindLit,
    KindCap,
    KindOpt,
    KindAlt,
    KindEnd,
    KindErr
  } kind_e;

  typedef enum logic [2:0] {
    CauseNone,
    CauseNoName,
    CauseUnclosed,
    CauseAltNoOpen,
    CauseStrayQm
  } cause_e;

  typedef struct packed {
    kind_e               kind;
    logic [StartW-1:0]   start;
    logic [LenW-1:0]     len;
    char_t               end_char;
    cause_e              cause;
    logic                last;
  } rec_t;

  typedef struct packed {
    logic [3:0]          phase;
    logic [PosW-1:0]     pos;
    logic [StartW-1:0]   tok_start;
    logic                esc;
    logic                opt;
    logic [StartW-1:0]   first_start;
    logic [LenW-1:0]     first_len;
    logic [LenW-1:0]     second_len;
  } state_t;

  localparam state_t StateReset = '0;

endpackage

// File: hw/rtl/lpep_step.sv
// Per-character parse step: next parser state and up to three result records.
module lpep_step (
  input  lpep_pkg::state_t st_i,
  input  lpep_pkg::char_t  ch_i,
  output lpep_pkg::state_t st_o,
  output lpep_pkg::rec_t   recs_o [lpep_pkg::MaxRecs],
  output logic [lpep_pkg::RecCntW-1:0] n_o
);
  import lpep_pkg::*;

  typedef struct packed {
    state_t s;
    logic   rec_v;
    rec_t   rec;
    logic   restart;
  } top_res_t;

  function automatic logic [StartW-1:0] clamp_start(logic [PosW-1:0] p);
    if (p > PosW'(MaxExprLen - 1)) return StartW'(MaxExprLen - 1);
    return p[StartW-1:0];
  endfunction

  function automatic logic [LenW-1:0] span(logic [PosW-1:0] p, logic [StartW-1:0] tok);
    logic [PosW-1:0] t;
    t = PosW'(tok);
    if (p >= t) return LenW'(p - t);
    return '0;
  endfunction

  function automatic rec_t mk_rec(kind_e k, logic [StartW-1:0] s, logic [LenW-1:0] l,
                                  char_t e, cause_e c);
    rec_t r;
    r.kind     = k;
    r.start    = s;
    r.len      = l;
    r.end_char = e;
    r.cause    = c;
    r.last     = 1'b0;
    return r;
  endfunction

  function automatic logic is_name_char(char_t c);
    return (c != ChNul) && (c != ChLt) && (c != ChGt) && (c != ChQm);
  endfunction

  // handling of a character seen at top level
  function automatic top_res_t top_level(state_t s_in, char_t c);
    top_res_t r;
    r.s       = s_in;
    r.rec_v   = 1'b0;
    r.rec     = '0;
    r.restart = 1'b0;
    r.s.phase = PhTop;
    r.s.esc   = 1'b0;
    if (c == ChNul) begin
      r.rec_v   = 1'b1;
      r.rec     = mk_rec(KindEnd, '0, '0, ChNul, CauseNone);
      r.restart = 1'b1;
    end else if (c == ChLt) begin
      r.s.opt   = 1'b0;
      r.s.phase = PhOpen;
    end else if (c == ChGt) begin
      r.rec_v = 1'b1;
      r.rec   = mk_rec(KindLit, clamp_start(s_in.pos), LenW'(1), ChNul, CauseNone);
    end else if (c == ChQm) begin
      r.rec_v   = 1'b1;
      r.rec     = mk_rec(KindErr, '0, '0, ChNul, CauseStrayQm);
      r.restart = 1'b1;
    end else begin
      r.s.tok_start = clamp_start(s_in.pos);
      r.s.esc       = (c == ChBsl);
      r.s.phase     = PhLit;
    end
    return r;
  endfunction

  top_res_t tl;
  assign tl = top_level(st_i, ch_i);

  always_comb begin
    logic [RecCntW-1:0] n;
    logic               restart;
    logic               ended;
    state_t             s;
    s       = st_i;
    n       = '0;
    restart = 1'b0;
    ended   = 1'b0;
    for (int i = 0; i < MaxRecs; i++) recs_o[i] = '0;

    // name/literal scan: escape holds the next character unless it is the terminator
    if (st_i.esc && ch_i != ChNul) begin
      ended = 1'b0;
    end else begin
      ended = (ch_i == ChNul) || (ch_i == ChLt) || (ch_i == ChGt);
    end

    unique case (st_i.phase)
      PhLit: begin
        if (!ended) begin
          s.esc = st_i.esc ? 1'b0 : (ch_i == ChBsl);
        end else begin
          recs_o[n] = mk_rec(KindLit, st_i.tok_start, span(st_i.pos, st_i.tok_start),
                             ChNul, CauseNone);
          n = n + 1'b1;
          s = tl.s;
          if (tl.rec_v) begin
            recs_o[n] = tl.rec;
            n = n + 1'b1;
          end
          restart = tl.restart;
        end
      end
      PhOpen, PhOpt, PhAltOpen: begin
        if (st_i.phase == PhOpen && ch_i == ChQm) begin
          s.opt   = 1'b1;
          s.phase = PhOpt;
        end else if (!is_name_char(ch_i)) begin
          recs_o[n] = mk_rec(KindErr, '0, '0, ChNul, CauseNoName);
          n = n + 1'b1;
          restart = 1'b1;
        end else begin
          s.tok_start = clamp_start(st_i.pos);
          s.esc       = (ch_i == ChBsl);
          s.phase     = (st_i.phase == PhAltOpen) ? PhAltName : PhName;
        end
      end
      PhName, PhAltName: begin
        if (!ended) begin
          s.esc = st_i.esc ? 1'b0 : (ch_i == ChBsl);
        end else if (ch_i == ChGt) begin
          if (st_i.phase == PhName) begin
            s.first_start = st_i.tok_start;
            s.first_len   = span(st_i.pos, st_i.tok_start);
            s.phase       = PhClosed;
          end else begin
            s.second_len  = span(st_i.pos, st_i.tok_start);
            s.phase       = PhAltClosed;
          end
        end else begin
          recs_o[n] = mk_rec(KindErr, '0, '0, ChNul, CauseUnclosed);
          n = n + 1'b1;
          restart = 1'b1;
        end
      end
      PhClosed: begin
        if (ch_i == ChQm) begin
          s.phase = PhAltQ;
        end else begin
          recs_o[n] = mk_rec(st_i.opt ? KindOpt : KindCap, st_i.first_start,
                             st_i.first_len, ch_i, CauseNone);
          n = n + 1'b1;
          s = tl.s;
          if (tl.rec_v) begin
            recs_o[n] = tl.rec;
            n = n + 1'b1;
          end
          restart = tl.restart;
        end
      end
      PhAltQ: begin
        if (ch_i == ChLt) begin
          s.phase = PhAltOpen;
        end else begin
          recs_o[n] = mk_rec(KindErr, '0, '0, ChNul, CauseAltNoOpen);
          n = n + 1'b1;
          restart = 1'b1;
        end
      end
      PhAltClosed: begin
        recs_o[n] = mk_rec(KindAlt, st_i.first_start, st_i.first_len, ch_i, CauseNone);
        n = n + 1'b1;
        recs_o[n] = mk_rec(KindCap, st_i.tok_start, st_i.second_len, ch_i, CauseNone);
        n = n + 1'b1;
        s = tl.s;
        if (tl.rec_v) begin
          recs_o[n] = tl.rec;
          n = n + 1'b1;
        end
        restart = tl.restart;
      end
      default: begin
        s = tl.s;
        if (tl.rec_v) begin
          recs_o[n] = tl.rec;
          n = n + 1'b1;
        end
        restart = tl.restart;
      end
    endcase

    if (restart) begin
      s = StateReset;
    end else if (st_i.pos < PosW'(MaxExprLen)) begin
      s.pos = st_i.pos + 1'b1;
    end

    if (n != '0) recs_o[n - 1'b1].last = 1'b1;

    st_o = s;
    n_o  = n;
  end

endmodule

// File: hw/rtl/lpep_rec_queue.sv
// Result record queue: takes up to three records per cycle, hands out one.
module lpep_rec_queue (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  logic [lpep_pkg::RecCntW-1:0] push_n_i,
  input  lpep_pkg::rec_t               push_recs_i [lpep_pkg::MaxRecs],
  input  logic                         pop_i,
  output logic                         full_o,
  output logic                         valid_o,
  output lpep_pkg::rec_t               rec_o
);
  import lpep_pkg::*;

  rec_t                 mem [QueueDepth];
  logic [QueuePtrW-1:0] wr_q, wr_d;
  logic [QueuePtrW-1:0] rd_q, rd_d;
  logic [QueueCntW-1:0] cnt_q, cnt_d;
  logic [RecCntW-1:0]   n_in;

  assign n_in    = push_i ? push_n_i : '0;
  assign valid_o = (cnt_q != '0);
  assign rec_o   = mem[rd_q];
  // not enough room for a worst-case transaction
  assign full_o  = (cnt_q > QueueCntW'(QueueDepth - MaxRecs));

  assign wr_d  = wr_q + QueuePtrW'(n_in);
  assign rd_d  = rd_q + QueuePtrW'(pop_i);
  assign cnt_d = cnt_q + QueueCntW'(n_in) - QueueCntW'(pop_i);

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MaxRecs; i++) begin
      if (RecCntW'(i) < n_in) mem[wr_q + QueuePtrW'(i)] <= push_recs_i[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// File: hw/rtl/log_pattern_expression_parser.sv
// Top level of the log-pattern expression parser.
//
// Takes one template character per cycle (ch_i, a zero byte ends the template)
// and emits expression records: literals, captures <name>, optional captures
// <?name>, alternatives <a>?<b> (a kind-3 record for the first name followed by
// a kind-1 record for the second), an end record, or an error record that also
// resets the parser. A capture record comes out with the character after its
// closing '>', since that character is its end_char. Each accepted character
// is parsed in the cycle it arrives; its zero to three records enter an
// 8-entry result queue in one step and leave it one per cycle while stall_i is
// low, the first at the earliest the cycle after the input transaction. Input
// therefore runs at one character per cycle; stall_o rises only while the
// queue has fewer than three free entries, so the sustained rate is set by
// the one-record-per-cycle output port when records outnumber characters.
module log_pattern_expression_parser (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // character input channel
  input  logic                             valid_i,
  output logic                             stall_o,
  input  logic [7:0]                       ch_i,
  // record output channel
  output logic                             valid_o,
  input  logic                             stall_i,
  output logic [2:0]                       kind_o,
  output logic [lpep_pkg::StartW-1:0]      start_res_o,
  output logic [lpep_pkg::LenW-1:0]        length_o,
  output logic [7:0]                       end_char_o,
  output logic [2:0]                       error_cause_o,
  output logic                             last_o
);
  import lpep_pkg::*;

  state_t             st_q, st_d;
  rec_t               step_recs [MaxRecs];
  logic [RecCntW-1:0] step_n;
  logic               in_acc;
  logic               full;
  rec_t               head;

  // input transaction
  assign in_acc  = valid_i && !stall_o;
  assign stall_o = full;

  // parse step: purely combinational from the parser state and the new character
  lpep_step u_step (
    .st_i   (st_q),
    .ch_i   (ch_i),
    .st_o   (st_d),
    .recs_o (step_recs),
    .n_o    (step_n)
  );

  // parser state moves only on an accepted character
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StateReset;
    end else if (in_acc) begin
      st_q <= st_d;
    end
  end

  // records wait here until the output side takes them
  lpep_rec_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_acc),
    .push_n_i    (step_n),
    .push_recs_i (step_recs),
    .pop_i       (valid_o && !stall_i),
    .full_o      (full),
    .valid_o     (valid_o),
    .rec_o       (head)
  );

  assign kind_o        = head.kind;
  assign start_res_o   = head.start;
  assign length_o      = head.len;
  assign end_char_o    = head.end_char;
  assign error_cause_o = head.cause;
  assign last_o        = head.last;

endmodule
